// File: rtl/core/tga_dec_pkg.sv
package tga_dec_pkg;

  // Configuration register indexes (byte address 4 * index).
  localparam logic CFG_IDX_BPP   = 1'b0;
  localparam logic CFG_IDX_TOTAL = 1'b1;

  localparam int CFG_ADDR_W = 3;

  // Reset values of the configuration registers.
  localparam logic [2:0]  BPP_RESET   = 3'd3;
  localparam logic [31:0] TOTAL_RESET = 32'd0;

  // Packet header fields.
  localparam logic [7:0] RUN_FLAG   = 8'h80;
  localparam logic [7:0] COUNT_MASK = 8'h7f;

  // Depth of the result queue between the parser and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_last;
  } out_t;

  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic [31:0] total_pixels;
  } cfg_t;

  // Queue status seen by the parser and the output stage.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: rtl/core/tga_dec_front.sv
module tga_dec_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tga_dec_pkg::in_t      in_data,
  input  tga_dec_pkg::cfg_t     cfg,
  input  tga_dec_pkg::queue_stat_t qstat,
  output logic                  push,
  output tga_dec_pkg::out_t     push_data
);

  localparam logic [7:0] RUN_FLAG_L   = tga_dec_pkg::RUN_FLAG;
  localparam logic [7:0] COUNT_MASK_L = tga_dec_pkg::COUNT_MASK;

  logic        in_packet, in_packet_next;
  logic        run_packet, run_packet_next;
  logic [7:0]  pixels_left, pixels_left_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [23:0] pixel_gather, pixel_gather_next;
  logic [31:0] pixels_done, pixels_done_next;
  logic        image_finished, image_finished_next;

  // State as seen by the current byte, after an image start clears it.
  logic        c_in_packet;
  logic        c_run;
  logic [7:0]  c_left;
  logic [1:0]  c_pos;
  logic [23:0] c_gather;
  logic [31:0] c_done;
  logic        c_fin;

  logic        accept;
  logic        ignore;
  logic [1:0]  last_pos;
  logic [31:0] remaining;
  logic [7:0]  count;
  logic        clip;
  logic [31:0] pixel;

  // Every byte needs a free queue slot, whether or not it finishes a pixel.
  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    c_in_packet = in_data.image_start ? 1'b0  : in_packet;
    c_run       = in_data.image_start ? 1'b0  : run_packet;
    c_left      = in_data.image_start ? 8'd0  : pixels_left;
    c_pos       = in_data.image_start ? 2'd0  : byte_position;
    c_gather    = in_data.image_start ? 24'd0 : pixel_gather;
    c_done      = in_data.image_start ? 32'd0 : pixels_done;
    c_fin       = in_data.image_start ? 1'b0  : image_finished;

    // Anything but a pixel size of four acts as three.
    last_pos  = (cfg.bytes_per_pixel == 3'd4) ? 2'd3 : 2'd2;
    ignore    = c_fin || (c_done >= cfg.total_pixels);
    remaining = cfg.total_pixels - c_done;
    count     = c_run ? c_left : 8'd1;
    clip      = remaining <= {24'd0, count};
    pixel     = {8'd0, c_gather} | ({24'd0, in_data.data_byte} << {c_pos, 3'b000});

    in_packet_next      = in_packet;
    run_packet_next     = run_packet;
    pixels_left_next    = pixels_left;
    byte_position_next  = byte_position;
    pixel_gather_next   = pixel_gather;
    pixels_done_next    = pixels_done;
    image_finished_next = image_finished;
    push                = 1'b0;
    push_data.pixel_value  = pixel;
    push_data.repeat_count = clip ? remaining[7:0] : count;
    push_data.image_last   = clip;

    if (accept) begin
      in_packet_next      = c_in_packet;
      run_packet_next     = c_run;
      pixels_left_next    = c_left;
      byte_position_next  = c_pos;
      pixel_gather_next   = c_gather;
      pixels_done_next    = c_done;
      image_finished_next = c_fin;
      if (!ignore) begin
        if (!c_in_packet) begin
          // Packet header.
          in_packet_next     = 1'b1;
          run_packet_next    = (in_data.data_byte & RUN_FLAG_L) != 8'd0;
          pixels_left_next   = (in_data.data_byte & COUNT_MASK_L) + 8'd1;
          byte_position_next = 2'd0;
          pixel_gather_next  = 24'd0;
        end else if (c_pos < last_pos) begin
          // Gather one more byte of the pixel.
          case (c_pos)
            2'd0:    pixel_gather_next = {c_gather[23:8], in_data.data_byte};
            2'd1:    pixel_gather_next = {c_gather[23:16], in_data.data_byte,
                                          c_gather[7:0]};
            default: pixel_gather_next = {in_data.data_byte, c_gather[15:0]};
          endcase
          byte_position_next = c_pos + 2'd1;
        end else begin
          // Final byte of the pixel: emit one result.
          push               = 1'b1;
          byte_position_next = 2'd0;
          pixel_gather_next  = 24'd0;
          if (c_run) begin
            pixels_left_next = 8'd0;
            in_packet_next   = 1'b0;
          end else begin
            pixels_left_next = c_left - 8'd1;
            in_packet_next   = (c_left != 8'd1);
          end
          pixels_done_next    = clip ? cfg.total_pixels : c_done + {24'd0, count};
          image_finished_next = clip;
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet      <= 1'b0;
      run_packet     <= 1'b0;
      pixels_left    <= 8'd0;
      byte_position  <= 2'd0;
      pixel_gather   <= 24'd0;
      pixels_done    <= 32'd0;
      image_finished <= 1'b0;
    end else begin
      in_packet      <= in_packet_next;
      run_packet     <= run_packet_next;
      pixels_left    <= pixels_left_next;
      byte_position  <= byte_position_next;
      pixel_gather   <= pixel_gather_next;
      pixels_done    <= pixels_done_next;
      image_finished <= image_finished_next;
    end
  end

endmodule

// File: rtl/core/tga_dec_queue.sv
module tga_dec_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  tga_dec_pkg::out_t        push_data,
  input  logic                     pop,
  output tga_dec_pkg::out_t        pop_data,
  output tga_dec_pkg::queue_stat_t qstat
);

  tga_dec_pkg::out_t entries [tga_dec_pkg::QUEUE_DEPTH];

  logic [tga_dec_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [tga_dec_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [tga_dec_pkg::QUEUE_CNT_W-1:0] fill;

  localparam logic [tga_dec_pkg::QUEUE_CNT_W-1:0] FULL_FILL =
    tga_dec_pkg::QUEUE_CNT_W'(tga_dec_pkg::QUEUE_DEPTH);

  assign qstat.full  = (fill == FULL_FILL);
  assign qstat.empty = (fill == '0);
  assign pop_data    = entries[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/tga_dec_back.sv
module tga_dec_back (
  input  logic                     clk,
  input  logic                     rst,
  input  tga_dec_pkg::queue_stat_t qstat,
  input  tga_dec_pkg::out_t        pop_data,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tga_dec_pkg::out_t        out_data
);

  // Refill the output register when it is empty or its transfer completes.
  assign pop = !qstat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= pop_data;
    end
  end

endmodule

// File: rtl/core/tga_rle_pixel_decoder_core.sv
// A result passes through the result queue and then the output register before it appears on out_valid.
// Throughput: one byte per cycle; the parser accepts a byte whenever the four-entry
// result queue has a free slot, so a stalled output only throttles input once it fills.
// Reset (rst, synchronous): parser state, queue and output valid are cleared,
// bytes_per_pixel returns to 3 and total_pixels to 0.
module tga_rle_pixel_decoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tga_dec_pkg::in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tga_dec_pkg::out_t                   out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tga_dec_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  tga_dec_pkg::cfg_t        cfg;
  tga_dec_pkg::queue_stat_t qstat;
  tga_dec_pkg::out_t        push_data;
  tga_dec_pkg::out_t        pop_data;
  logic                     push;
  logic                     pop;
  logic                     cfg_write;
  logic                     reg_idx;

  // Configuration port: writes complete in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_pixel <= tga_dec_pkg::BPP_RESET;
      cfg.total_pixels    <= tga_dec_pkg::TOTAL_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        tga_dec_pkg::CFG_IDX_BPP:   cfg.bytes_per_pixel <= pwdata[2:0];
        tga_dec_pkg::CFG_IDX_TOTAL: cfg.total_pixels    <= pwdata;
        default:                    cfg.total_pixels    <= cfg.total_pixels;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tga_dec_pkg::CFG_IDX_BPP:   prdata = {29'd0, cfg.bytes_per_pixel};
      tga_dec_pkg::CFG_IDX_TOTAL: prdata = cfg.total_pixels;
      default:                    prdata = 32'd0;
    endcase
  end

  tga_dec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  tga_dec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  tga_dec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The parser never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("result pushed into a full queue");

  // The output stage never reads an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("result popped from an empty queue");

  // A delivered result always covers at least one pixel.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.repeat_count != 8'd0)
    else $error("result with zero repeat count");

endmodule

// File: test/tb_top.sv
module tb_top;

  // Clock, reset and block ports.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tga_dec_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tga_dec_pkg::out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tga_dec_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Byte stream waiting to be sent, and pixel results still owed by the block.
  tga_dec_pkg::in_t stream_q[$];
  tga_dec_pkg::out_t expected_px[$];

  // Shadow of the configuration registers and of the decoder state.
  tga_dec_pkg::cfg_t cfg_shadow = '{bytes_per_pixel: tga_dec_pkg::BPP_RESET,
                                    total_pixels: tga_dec_pkg::TOTAL_RESET};
  logic in_pkt;
  logic is_run;
  logic img_done;
  logic [7:0] pkt_left;
  logic [1:0] pos;
  logic [23:0] gather;
  logic [31:0] covered;

  // Idle settings per phase and bookkeeping.
  int tx_max = 0;
  int rx_max = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned hold_clock = 0;
  int unsigned next_hold = 300;
  int fails = 0;
  int bytes_in = 0;
  int results_ok = 0;
  int images_seen = 0;
  int phase_cnt = 0;

  tga_rle_pixel_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decoder state after reset or at the start of an image.
  function automatic void clear_decoder();
    in_pkt = 1'b0;
    is_run = 1'b0;
    img_done = 1'b0;
    pkt_left = '0;
    pos = '0;
    gather = '0;
    covered = '0;
  endfunction

  // Advance the decoder by one byte and queue the pixel result it completes, if any.
  function automatic void decode_byte(input tga_dec_pkg::in_t item);
    logic [31:0] px;
    logic [31:0] cnt;
    logic [31:0] left_img;
    int unsigned px_bytes;
    tga_dec_pkg::out_t res;
    px_bytes = (cfg_shadow.bytes_per_pixel == 3'd4) ? 4 : 3;
    if (item.image_start) clear_decoder();
    if (img_done || covered >= cfg_shadow.total_pixels) return;
    // A header opens a run or a raw packet.
    if (!in_pkt) begin
      in_pkt = 1'b1;
      is_run = (item.data_byte & tga_dec_pkg::RUN_FLAG) != 8'h00;
      pkt_left = (item.data_byte & tga_dec_pkg::COUNT_MASK) + 8'd1;
      pos = '0;
      gather = '0;
      return;
    end
    if (pos + 1 < px_bytes) begin
      gather = gather | (24'(item.data_byte) << (8 * pos));
      pos = pos + 2'd1;
      return;
    end
    // The pixel is complete; a run covers its whole count, clipped at the image end.
    px = {8'h00, gather} | (32'(item.data_byte) << (8 * pos));
    pos = '0;
    gather = '0;
    left_img = cfg_shadow.total_pixels - covered;
    if (is_run) begin
      cnt = {24'd0, pkt_left};
      if (cnt > left_img) cnt = left_img;
      pkt_left = '0;
      in_pkt = 1'b0;
    end else begin
      cnt = 32'd1;
      pkt_left = pkt_left - 8'd1;
      if (pkt_left == 8'd0) in_pkt = 1'b0;
    end
    covered = covered + cnt;
    if (covered == cfg_shadow.total_pixels) img_done = 1'b1;
    res.pixel_value = px;
    res.repeat_count = cnt[7:0];
    res.image_last = img_done;
    expected_px.push_back(res);
  endfunction

  function automatic void note_fail(input string what, input tga_dec_pkg::out_t want,
                                    input tga_dec_pkg::out_t got);
    fails++;
    if (fails <= 10)
      $display("%s: expected px=%h cnt=%0d last=%b, got px=%h cnt=%0d last=%b", what,
               want.pixel_value, want.repeat_count, want.image_last,
               got.pixel_value, got.repeat_count, got.image_last);
  endfunction

  // Compare one received pixel result with the oldest one owed.
  function automatic void check_pixel(input tga_dec_pkg::out_t got);
    tga_dec_pkg::out_t want;
    if (expected_px.size() == 0) begin
      note_fail("result with none owed", '0, got);
      return;
    end
    want = expected_px.pop_front();
    if (got.pixel_value !== want.pixel_value || got.repeat_count !== want.repeat_count ||
        got.image_last !== want.image_last)
      note_fail("pixel result differs", want, got);
    else
      results_ok++;
  endfunction

  // Byte driver: predicts on every transfer, then waits a random gap before the next byte.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data);
        bytes_in++;
        tx_wait = $urandom_range(0, tx_max);
      end
      if (!in_valid || in_ready) begin
        if (tx_wait != 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (stream_q.size() != 0) begin
          in_data <= stream_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started while a result is waiting so the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_clock <= 0;
    end else begin
      hold_clock <= hold_clock + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_clock >= next_hold && out_valid) begin
        hold_left <= 90;
        next_hold <= hold_clock + 1000;
      end
    end
  end

  // Result monitor with a random stall after every transfer.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_pixel(out_data);
        if (out_data.image_last) images_seen++;
        rx_wait = $urandom_range(0, rx_max);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // Register write: setup cycle, then access cycle; the write lands at the end of the access cycle.
  task automatic apb_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [2:0] bpp, input logic [31:0] total);
    apb_write(tga_dec_pkg::CFG_IDX_BPP, {29'd0, bpp});
    cfg_shadow.bytes_per_pixel = bpp;
    apb_write(tga_dec_pkg::CFG_IDX_TOTAL, total);
    cfg_shadow.total_pixels = total;
    @(negedge clk);
  endtask

  // Wait until every byte is sent and every owed result has come, then let the pipe settle.
  task automatic drain();
    while (stream_q.size() != 0 || in_valid || expected_px.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic s);
    tga_dec_pkg::in_t item;
    item.data_byte = b;
    item.image_start = s;
    stream_q.push_back(item);
  endtask

  // Well-formed packets with random pixels until the image covers target pixels.
  task automatic push_image(input int target, input int px_bytes, input logic start);
    int done_px;
    int k;
    logic run;
    logic s;
    done_px = 0;
    s = start;
    while (done_px < target) begin
      k = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
      run = $urandom_range(0, 1);
      if (!run && k > 16 && $urandom_range(0, 3) != 0) k = $urandom_range(1, 8);
      push_byte(run ? (tga_dec_pkg::RUN_FLAG | 8'(k - 1)) : 8'(k - 1), s);
      s = 1'b0;
      repeat (run ? 1 : k) repeat (px_bytes) push_byte(8'($urandom), 1'b0);
      done_px += k;
    end
  endtask

  // One phase: new register settings, a stream of images with some noise, then drain.
  task automatic run_phase(input logic [2:0] bpp, input logic [31:0] total, input int budget,
                           input logic cont, input logic cut);
    int px_bytes;
    int target;
    logic start;
    configure(bpp, total);
    tx_max = $urandom_range(0, 1) * 4;
    rx_max = $urandom_range(0, 1) * 4;
    px_bytes = (bpp == 3'd4) ? 4 : 3;
    start = !cont;
    while (stream_q.size() < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        if (total == 0 || total > 200) target = $urandom_range(1, 40);
        else target = total + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
        push_image(target, px_bytes, start);
        start = 1'b1;
      end
    end
    // Cutting the tail leaves the image open, often in the middle of a pixel.
    if (cut) repeat ($urandom_range(1, 5)) if (stream_q.size() != 0) void'(stream_q.pop_back());
    drain();
    phase_cnt++;
  endtask

  initial begin
    logic [2:0] bpp_sel;
    logic [31:0] total_sel;
    int r;
    clear_decoder();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: a run, a raw packet ending the image, a byte past the end, a clipped run.
    configure(3'd3, 32'd5);
    push_byte(8'h82, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0); push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0); push_byte(8'h44, 1'b0); push_byte(8'h55, 1'b0);
    push_byte(8'h66, 1'b0); push_byte(8'hAB, 1'b0);
    push_byte(8'hFF, 1'b1); push_byte(8'h7F, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b0);
    drain();
    // Directed: 4-byte pixels, a raw packet that runs past the image end.
    configure(3'd4, 32'd2);
    push_byte(8'h03, 1'b1); push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0); push_byte(8'h04, 1'b0); push_byte(8'hF0, 1'b0);
    push_byte(8'h0F, 1'b0); push_byte(8'hAA, 1'b0); push_byte(8'h55, 1'b0);
    push_byte(8'h99, 1'b0);
    drain();

    // Extreme settings: odd pixel size with a huge image left open, then a change
    // mid-image that drops the pixel count below what is done, an empty image, one pixel.
    run_phase(3'd0, 32'hFFFF_FFFF, 120, 1'b0, 1'b1);
    run_phase(3'd4, 32'd2, 60, 1'b1, 1'b0);
    run_phase(3'd7, 32'd0, 30, 1'b0, 1'b0);
    run_phase(3'd4, 32'd1, 40, 1'b0, 1'b1);

    // Random settings, mostly small images.
    while (bytes_in < 1600) begin
      r = $urandom_range(0, 9);
      bpp_sel = (r < 4) ? 3'd3 : (r < 8) ? 3'd4 : 3'($urandom_range(0, 7));
      r = $urandom_range(0, 19);
      total_sel = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? $urandom :
                  32'($urandom_range(1, 40));
      run_phase(bpp_sel, total_sel, $urandom_range(60, 160), $urandom_range(0, 2) == 0,
                $urandom_range(0, 2) == 0);
    end

    repeat (8) @(negedge clk);
    $display("Sent %0d stream bytes over %0d register settings.", bytes_in, phase_cnt + 2);
    $display("Checked %0d pixel results, %0d of them closing an image.", results_ok,
             images_seen);
    if (fails == 0) begin
      $display("tga_rle_pixel_decoder_core: match");
    end else begin
      $display("%0d failing results", fails);
      $display("tga_rle_pixel_decoder_core: mismatch");
    end
    $finish;
  end

  // Watchdog in case the block stops moving.
  initial begin
    #(400000 * 4);
    $display("tga_rle_pixel_decoder_core: mismatch");
    $finish;
  end

endmodule
